// ===== rtl/core/fcru_pkg.sv =====
// package: types, constants and bit-step function of the rle unpacker
`default_nettype none
package fcru_pkg;

    localparam int TRACK_BYTES_DEF = 4096;
    localparam int FAV_COUNT = 20;
    localparam int TF_W = 13;
    localparam int MAX_RES = 4;

    typedef enum logic [3:0] {
        PH_SKIP, PH_MARKER, PH_VOLUME, PH_FAVS, PH_FLAG,
        PH_LITERAL, PH_PREFIX, PH_RUNPAD, PH_RUNCHAR, PH_RUNCOUNT
    } t_phase;

    typedef enum logic [1:0] {
        KIND_VOLUME = 2'd0, KIND_RUN = 2'd1, KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0, ERR_MARKER = 2'd1, ERR_OVERRUN = 2'd2
    } t_err;

    localparam logic [1:0] CFG_HEADER_SKIP = 2'd0;
    localparam logic [1:0] CFG_TRACK_TOTAL = 2'd1;

    typedef struct packed {
        logic       start_image;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [8:0] repeat_res;
        logic [7:0] track_number;
        logic       track_done;
        logic       image_done;
        logic [1:0] error_code;
        logic       last;
    } t_res;

    typedef struct packed {
        t_phase          phase;
        logic [2:0]      skip_left;
        logic [7:0]      field_shift;
        logic [3:0]      field_bits;
        logic [4:0]      favorite_fill;
        logic [TF_W-1:0] track_fill;
        logic [7:0]      track_index;
        logic [7:0]      run_value;
        logic            halted;
    } t_state;

    typedef logic [FAV_COUNT-1:0][7:0] t_favs;

    typedef struct packed {
        t_state s;
        t_favs  favs;
        logic   emit;
        t_res   res;
    } t_step;

    localparam logic [FAV_COUNT-1:0][7:0] CODE_TABLE = {
        8'h1c, 8'h1d, 8'h35, 8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0f,
        8'h1b, 8'h05, 8'h06, 8'h0a, 8'h0b, 8'h0c, 8'h0e, 8'h0f, 8'h01, 8'h04
    };

    function automatic logic [1:0] code_len(input int k);
        if (k < 2) return 2'd0;
        else if (k < 9) return 2'd1;
        else if (k < 17) return 2'd2;
        else return 2'd3;
    endfunction

    function automatic t_step deliver(input t_step st, input logic [7:0] value,
                                      input logic [8:0] cnt, input logic [7:0] track_total,
                                      input logic [TF_W:0] track_bytes);
        t_step o;
        logic [TF_W:0] sum;
        logic done;
        logic idone;
        o = st;
        sum = {1'b0, st.s.track_fill} + (TF_W+1)'(cnt);
        done = sum >= track_bytes;
        idone = 1'b0;
        o.s.field_shift = '0;
        o.s.field_bits = '0;
        o.s.track_fill = sum[TF_W-1:0];
        if (done) begin
            o.s.track_index = st.s.track_index + 8'd1;
            idone = (o.s.track_index == track_total);
            if (idone) begin
                o.s.halted = 1'b1;
            end else begin
                o.s.phase = PH_FAVS;
                o.s.favorite_fill = '0;
            end
            o.s.track_fill = '0;
        end else begin
            o.s.phase = PH_FLAG;
        end
        o.emit = 1'b1;
        o.res = '{kind: KIND_RUN, value: value, repeat_res: cnt,
                  track_number: st.s.track_index, track_done: done,
                  image_done: idone, error_code: ERR_NONE, last: 1'b0};
        return o;
    endfunction

    function automatic t_step fail(input t_step st, input t_err code);
        t_step o;
        o = st;
        o.emit = 1'b1;
        o.res = '{kind: KIND_ERROR, value: 8'd0, repeat_res: 9'd0,
                  track_number: st.s.track_index, track_done: 1'b0,
                  image_done: 1'b0, error_code: code, last: 1'b0};
        o.s.halted = 1'b1;
        return o;
    endfunction

    function automatic t_step step_bit(input t_state s, input t_favs favs,
                                       input logic b, input logic [7:0] track_total,
                                       input logic [TF_W:0] track_bytes);
        t_step o;
        logic [7:0] sh;
        logic [3:0] nb;
        logic [1:0] len;
        logic found;
        logic [7:0] fv;
        logic [8:0] cnt;
        o.s = s;
        o.favs = favs;
        o.emit = 1'b0;
        o.res = '0;
        sh = {b, s.field_shift[7:1]};
        nb = s.field_bits + 4'd1;
        found = 1'b0;
        fv = '0;
        len = '0;
        cnt = '0;
        case (s.phase)
            PH_MARKER: begin
                o.s.field_shift = s.field_shift | {7'd0, b};
                o.s.field_bits = nb;
                if (nb >= 4'd3) begin
                    if (o.s.field_shift != 8'd0) begin
                        o = fail(o, ERR_MARKER);
                    end else begin
                        o.s.field_shift = '0;
                        o.s.field_bits = '0;
                        o.s.phase = PH_VOLUME;
                    end
                end
            end
            PH_VOLUME: begin
                o.s.field_shift = sh;
                o.s.field_bits = nb;
                if (nb >= 4'd8) begin
                    o.emit = 1'b1;
                    o.res = '{kind: KIND_VOLUME, value: sh, repeat_res: 9'd1,
                              track_number: 8'd0, track_done: 1'b0,
                              image_done: 1'b0, error_code: ERR_NONE, last: 1'b0};
                    o.s.field_shift = '0;
                    o.s.field_bits = '0;
                    o.s.phase = PH_FAVS;
                    o.s.favorite_fill = '0;
                end
            end
            PH_FAVS: begin
                o.s.field_shift = sh;
                o.s.field_bits = nb;
                if (nb >= 4'd8) begin
                    for (int k = 0; k < FAV_COUNT; k++) begin
                        if (s.favorite_fill == 5'(k)) o.favs[k] = sh;
                    end
                    o.s.favorite_fill = s.favorite_fill + 5'd1;
                    o.s.field_shift = '0;
                    o.s.field_bits = '0;
                    if (o.s.favorite_fill >= 5'(FAV_COUNT)) begin
                        o.s.phase = PH_FLAG;
                        o.s.track_fill = '0;
                    end
                end
            end
            PH_FLAG: begin
                o.s.field_shift = '0;
                o.s.field_bits = '0;
                o.s.phase = b ? PH_PREFIX : PH_LITERAL;
            end
            PH_LITERAL: begin
                o.s.field_shift = sh;
                o.s.field_bits = nb;
                if (nb >= 4'd8) o = deliver(o, sh, 9'd1, track_total, track_bytes);
            end
            PH_PREFIX: begin
                o.s.field_shift = {s.field_shift[6:0], b};
                o.s.field_bits = nb;
                if (nb >= 4'd3) begin
                    len = (nb >= 4'd6) ? 2'd3 : 2'(nb - 4'd3);
                    for (int k = FAV_COUNT - 1; k >= 0; k--) begin
                        if (code_len(k) == len && CODE_TABLE[k] == o.s.field_shift) begin
                            found = 1'b1;
                            fv = favs[k];
                        end
                    end
                    if (found) begin
                        o = deliver(o, fv, 9'd1, track_total, track_bytes);
                    end else if (nb >= 4'd6) begin
                        o.s.field_shift = '0;
                        o.s.field_bits = '0;
                        o.s.phase = PH_RUNPAD;
                    end
                end
            end
            PH_RUNPAD: begin
                o.s.field_shift = '0;
                o.s.field_bits = '0;
                o.s.phase = PH_RUNCHAR;
            end
            PH_RUNCHAR: begin
                o.s.field_shift = sh;
                o.s.field_bits = nb;
                if (nb >= 4'd8) begin
                    o.s.run_value = sh;
                    o.s.field_shift = '0;
                    o.s.field_bits = '0;
                    o.s.phase = PH_RUNCOUNT;
                end
            end
            PH_RUNCOUNT: begin
                o.s.field_shift = sh;
                o.s.field_bits = nb;
                if (nb >= 4'd8) begin
                    cnt = (sh == 8'd0) ? 9'd256 : {1'b0, sh};
                    if ({1'b0, s.track_fill} + (TF_W+1)'(cnt) > track_bytes) begin
                        o = fail(o, ERR_OVERRUN);
                    end else begin
                        o = deliver(o, s.run_value, cnt, track_total, track_bytes);
                    end
                end
            end
            default: begin
                o.s.halted = 1'b1;
            end
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fcru_decode.sv =====
// byte decoder: start and header handling, then eight unrolled bit steps
`default_nettype none
module fcru_decode #(
    parameter int TRACK_BYTES = fcru_pkg::TRACK_BYTES_DEF
) (
    input  fcru_pkg::t_in    i_in,
    input  fcru_pkg::t_state i_state,
    input  fcru_pkg::t_favs  i_favs,
    input  logic [2:0]       i_header_skip,
    input  logic [7:0]       i_track_total,
    output fcru_pkg::t_state o_state,
    output fcru_pkg::t_favs  o_favs,
    output fcru_pkg::t_res   o_res [fcru_pkg::MAX_RES],
    output logic [2:0]       o_count
);
    localparam logic [fcru_pkg::TF_W:0] TB = (fcru_pkg::TF_W+1)'(TRACK_BYTES);

    fcru_pkg::t_state s;
    fcru_pkg::t_favs  f;
    fcru_pkg::t_step  st;
    logic             go;
    logic [2:0]       n;

    always_comb begin
        s = i_state;
        f = i_favs;
        go = 1'b1;
        n = '0;
        st = '0;
        for (int j = 0; j < fcru_pkg::MAX_RES; j++) o_res[j] = '0;
        if (i_in.start_image) begin
            s.skip_left = i_header_skip;
            s.phase = fcru_pkg::PH_SKIP;
            s.field_shift = '0;
            s.field_bits = '0;
            s.favorite_fill = '0;
            s.track_fill = '0;
            s.track_index = '0;
            s.run_value = '0;
            s.halted = 1'b0;
        end
        if (s.halted) go = 1'b0;
        if (go && s.phase == fcru_pkg::PH_SKIP) begin
            if (s.skip_left != 3'd0) begin
                s.skip_left = s.skip_left - 3'd1;
                go = 1'b0;
            end else begin
                s.phase = fcru_pkg::PH_MARKER;
                s.field_shift = '0;
                s.field_bits = '0;
            end
        end
        for (int i = 0; i < 8; i++) begin
            if (go && !s.halted) begin
                st = fcru_pkg::step_bit(s, f, i_in.data_byte[7-i], i_track_total, TB);
                s = st.s;
                f = st.favs;
                if (st.emit && n < 3'(fcru_pkg::MAX_RES)) begin
                    o_res[n[1:0]] = st.res;
                    n = n + 3'd1;
                end
            end
        end
        for (int j = 0; j < fcru_pkg::MAX_RES; j++) begin
            if (n == 3'(j + 1)) o_res[j].last = 1'b1;
        end
        o_state = s;
        o_favs = f;
        o_count = n;
    end
endmodule
`default_nettype wire

// ===== rtl/core/fcru_outq.sv =====
// result buffer: holds one byte's results, handed out one per cycle on i_ready
`default_nettype none
module fcru_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  fcru_pkg::t_res i_res [fcru_pkg::MAX_RES],
    input  logic [2:0]     i_count,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output fcru_pkg::t_res o_res
);
    fcru_pkg::t_res r_buf [fcru_pkg::MAX_RES];
    logic [2:0]     r_cnt;
    logic [1:0]     r_rd;
    logic           take;

    assign o_valid = (r_cnt != 3'd0);
    assign take = o_valid && i_ready;
    assign o_room = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);
    assign o_res = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
            r_rd <= '0;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
            r_rd <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int j = 0; j < fcru_pkg::MAX_RES; j++) r_buf[j] <= i_res[j];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/favorite_code_rle_unpacker.sv =====
// top level: rle and favorite prefix code unpacker
// takes one compressed byte per cycle while the buffer has room; each byte yields zero to
// four results, which leave one per cycle while i_ready is high, so a byte is accepted
// every cycle while each yields at most one result and i_ready is high, else after its
// results drain; a byte decodes in eight combinational bit steps, parser state to buffer.
`default_nettype none
module favorite_code_rle_unpacker #(
    parameter int TRACK_BYTES = fcru_pkg::TRACK_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fcru_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output fcru_pkg::t_res o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data
);
    fcru_pkg::t_state r_state, n_state;
    fcru_pkg::t_favs  r_favs, n_favs;
    logic [2:0]       r_header_skip;
    logic [7:0]       r_track_total;
    fcru_pkg::t_res   res [fcru_pkg::MAX_RES];
    logic [2:0]       cnt;
    logic             acc;

    assign o_cfg_ready = 1'b1;
    assign acc = i_valid && o_ready;

    fcru_decode #(.TRACK_BYTES(TRACK_BYTES)) u_dec (
        .i_in(i_data), .i_state(r_state), .i_favs(r_favs),
        .i_header_skip(r_header_skip), .i_track_total(r_track_total),
        .o_state(n_state), .o_favs(n_favs), .o_res(res), .o_count(cnt)
    );

    fcru_outq u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(acc), .i_res(res),
        .i_count(cnt), .o_room(o_ready), .o_valid(o_valid),
        .i_ready(i_ready), .o_res(o_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: fcru_pkg::PH_SKIP, default: '0};
            r_header_skip <= 3'd4;
            r_track_total <= 8'd35;
        end else begin
            if (acc) r_state <= n_state;
            if (i_cfg_valid && i_cfg_index == fcru_pkg::CFG_HEADER_SKIP) begin
                r_header_skip <= i_cfg_data[2:0];
            end
            if (i_cfg_valid && i_cfg_index == fcru_pkg::CFG_TRACK_TOTAL) begin
                r_track_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_favs <= n_favs;
    end
endmodule
`default_nettype wire

// ===== rtl/core/fcru_checker.sv =====
// port checker for the unpacker and its bind
`default_nettype none
module fcru_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire fcru_pkg::t_res o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped while stalled");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == fcru_pkg::KIND_ERROR |->
            o_data.last && o_data.repeat_res == 9'd0)
        else $error("error result not final");
    a_run_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == fcru_pkg::KIND_RUN |-> o_data.repeat_res != 9'd0)
        else $error("run with zero repeat");
    a_img: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.image_done |-> o_data.track_done && o_data.last)
        else $error("image done without track done");
endmodule

bind favorite_code_rle_unpacker fcru_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid),
    .i_ready(i_ready), .o_data(o_data)
);
`default_nettype wire
